FILE: hw/rtl/bcdma_pkg.sv
// Package for the byte copy DMA controller: item and result types,
// register indexes, address constants and the address helper functions.
// No dependencies.
`timescale 1ns / 1ps

package bcdma_pkg;

    localparam int MAX_LENGTH = 512;
    localparam int LEN_W      = $clog2(MAX_LENGTH + 1);
    localparam int ADDR_W     = 25;
    localparam int REG_IDX_W  = 3;
    localparam int NUM_REGS   = 7;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 64;

    localparam logic [REG_IDX_W-1:0] REG_SRC_LO  = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_SRC_HI  = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_DST_LO  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_DST_HI  = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_BANK_LO = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_LEN     = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_BANK_HI = 3'd6;

    localparam logic [15:0]       VRAM_PORT_A  = 16'h2004;
    localparam logic [15:0]       VRAM_PORT_B  = 16'h2007;
    localparam logic [ADDR_W-1:0] CPU_RAM_MASK = 25'h1FFF;

    localparam logic KIND_READ = 1'b0;
    localparam logic KIND_COPY = 1'b1;

    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [LEN_W-1:0]  t_len;

    typedef enum logic [1:0] {
        OP_WRITE  = 2'd0,
        OP_READ   = 2'd1,
        OP_VBLANK = 2'd2,
        OP_TICK   = 2'd3
    } t_op;

    typedef struct packed {
        t_op                  op;
        logic [REG_IDX_W-1:0] reg_addr;
        logic [7:0]           write_data;
    } t_in_item;

    typedef struct packed {
        logic       kind;
        logic [7:0] read_data;
        t_addr      src_address;
        logic       src_external;
        t_addr      dst_address;
        logic       dst_external;
        logic       last_byte;
    } t_result;

    typedef struct packed {
        logic awaiting_vblank;
        logic transfer_active;
    } t_status;

    // Addresses with bit 15 set take their upper bits from the two bank registers.
    function automatic t_addr physical(input logic [15:0] a, input logic [7:0] bank_lo,
                                       input logic [7:0] bank_hi);
        t_addr p;
        p = t_addr'(a[14:0]);
        if (a[15]) begin
            p = p | (t_addr'(bank_lo) << 15) | (t_addr'(bank_hi[1:0]) << 23);
        end
        return p;
    endfunction

    // Transfer length is twice the register value; zero selects the maximum.
    function automatic t_len start_len(input logic [7:0] len_reg);
        logic [9:0] dbl;
        dbl = {1'b0, len_reg, 1'b0};
        if (dbl == 10'd0 || dbl > 10'(MAX_LENGTH)) begin
            return t_len'(MAX_LENGTH);
        end
        return t_len'(dbl);
    endfunction

endpackage

FILE: hw/rtl/byte_copy_dma_controller.sv
// Top level of the byte copy DMA controller: stream ports, input register,
// core and result register. Depends on bcdma_pkg, bcdma_in_stage, bcdma_core
// and bcdma_out_stage.
//
//  Channel  Direction  tdata                      tuser      tlast
//  s_axis   in         reg_addr, write_data       operation  -
//  m_axis   out        read_data .. dst_external  kind       last_byte
//
// One item is taken per clock cycle while s_axis tready is high; a clock tick
// item during a transfer yields one copy command, so a transfer of N bytes
// needs N tick transfers. The input register takes each item at its transfer
// edge; the core logic then loads the result, if any, into the result register
// once that register is free or being drained, and m_axis presents it there.
// Synchronous active-low reset clears the register file and all transfer state.
// When both registers are full, s_axis tready follows m_axis tready.
`timescale 1ns / 1ps

module byte_copy_dma_controller (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // [2:0] reg_addr, [10:3] write_data, [15:11] zero
    input  logic [bcdma_pkg::IN_DATA_W-1:0]     i_s_axis_tdata,
    // [1:0] operation
    input  logic [1:0]                          i_s_axis_tuser,
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // [7:0] read_data, [32:8] src_address, [33] src_external,
    // [58:34] dst_address, [59] dst_external, [63:60] zero
    output logic [bcdma_pkg::OUT_DATA_W-1:0]    o_m_axis_tdata,
    // [0] kind
    output logic                                o_m_axis_tuser,
    output logic                                o_m_axis_tlast
);

    bcdma_pkg::t_in_item w_in_item;
    bcdma_pkg::t_in_item w_item;
    logic                w_item_valid;
    logic                w_advance;
    logic                w_res_valid;
    bcdma_pkg::t_result  w_result;
    bcdma_pkg::t_result  w_out;
    bcdma_pkg::t_status  w_status;

    assign w_in_item.op         = bcdma_pkg::t_op'(i_s_axis_tuser);
    assign w_in_item.reg_addr   = i_s_axis_tdata[2:0];
    assign w_in_item.write_data = i_s_axis_tdata[10:3];

    // The held item moves on when the result register is free or being drained.
    assign w_advance = w_item_valid && (!o_m_axis_tvalid || i_m_axis_tready);

    bcdma_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_axis_tvalid),
        .o_ready   (o_s_axis_tready),
        .i_item    (w_in_item),
        .i_advance (w_advance),
        .o_valid   (w_item_valid),
        .o_item    (w_item)
    );

    bcdma_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (w_advance),
        .i_item      (w_item),
        .o_res_valid (w_res_valid),
        .o_result    (w_result),
        .o_status    (w_status)
    );

    bcdma_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_advance && w_res_valid),
        .i_result (w_result),
        .i_ready  (i_m_axis_tready),
        .o_valid  (o_m_axis_tvalid),
        .o_result (w_out)
    );

    assign o_m_axis_tdata = {4'd0, w_out.dst_external, w_out.dst_address,
                             w_out.src_external, w_out.src_address, w_out.read_data};
    assign o_m_axis_tuser = w_out.kind;
    assign o_m_axis_tlast = w_out.last_byte;

    // A start either waits for vblank or runs at once, never both.
    a_await_excl_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_status.awaiting_vblank && w_status.transfer_active))
        else $error("awaiting vblank while a transfer is active");

    // A tick during a transfer must produce a copy command.
    a_tick_copies: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && w_item.op == bcdma_pkg::OP_TICK && w_status.transfer_active)
        |-> (w_res_valid && w_result.kind == bcdma_pkg::KIND_COPY))
        else $error("tick during transfer gave no copy command");

    // Every produced result shows up on the output in the next cycle.
    a_result_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && w_res_valid) |=> o_m_axis_tvalid)
        else $error("result lost before the output register");

    // The final copy command ends the transfer.
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && w_res_valid && w_result.last_byte) |=> !w_status.transfer_active)
        else $error("transfer still active after its last byte");

endmodule

FILE: hw/rtl/bcdma_in_stage.sv
// Input register of the byte copy DMA controller.
// Holds one accepted item until the core consumes it; uses bcdma_pkg.
`timescale 1ns / 1ps

module bcdma_in_stage (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  bcdma_pkg::t_in_item i_item,
    input  logic                i_advance,
    output logic                o_valid,
    output bcdma_pkg::t_in_item o_item
);

    logic                r_valid;
    logic                n_valid;
    bcdma_pkg::t_in_item r_item;

    assign o_ready = !r_valid || i_advance;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_comb begin
        n_valid = r_valid;
        if (i_valid && o_ready) begin
            n_valid = 1'b1;
        end else if (i_advance) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

endmodule

FILE: hw/rtl/bcdma_core.sv
// Register file and transfer engine of the byte copy DMA controller.
// Applies one item per cycle while i_fire is high and forms its result; uses bcdma_pkg.
`timescale 1ns / 1ps

module bcdma_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  bcdma_pkg::t_in_item i_item,
    output logic                o_res_valid,
    output bcdma_pkg::t_result  o_result,
    output bcdma_pkg::t_status  o_status
);

    logic [7:0]       r_regs [bcdma_pkg::NUM_REGS];
    logic [7:0]       n_regs [bcdma_pkg::NUM_REGS];
    logic             r_await, n_await;
    logic             r_active, n_active;
    bcdma_pkg::t_addr r_src, n_src;
    bcdma_pkg::t_addr r_dst, n_dst;
    bcdma_pkg::t_len  r_left, n_left;
    logic             r_src_ext, n_src_ext;
    logic             r_dst_ext, n_dst_ext;
    logic             r_vram, n_vram;

    logic             busy;
    logic             do_start;
    logic [15:0]      src_word;
    logic [15:0]      dst_word;
    logic             dst_vram;
    logic [7:0]       rd_byte;
    bcdma_pkg::t_len  left_dec;

    assign busy = r_await || r_active;
    assign o_status.awaiting_vblank = r_await;
    assign o_status.transfer_active = r_active;

    // The register file as it stands after this item's write, if any.
    always_comb begin
        for (int i = 0; i < bcdma_pkg::NUM_REGS; i++) begin
            n_regs[i] = r_regs[i];
            if (i_fire && i_item.op == bcdma_pkg::OP_WRITE &&
                i_item.reg_addr == bcdma_pkg::REG_IDX_W'(i)) begin
                n_regs[i] = i_item.write_data;
            end
        end
    end

    assign src_word = {n_regs[bcdma_pkg::REG_SRC_HI], n_regs[bcdma_pkg::REG_SRC_LO]};
    assign dst_word = {n_regs[bcdma_pkg::REG_DST_HI], n_regs[bcdma_pkg::REG_DST_LO]};
    assign dst_vram = (dst_word == bcdma_pkg::VRAM_PORT_A) ||
                      (dst_word == bcdma_pkg::VRAM_PORT_B);

    always_comb begin
        rd_byte = 8'd0;
        for (int i = 0; i < bcdma_pkg::NUM_REGS; i++) begin
            if (i_item.reg_addr == bcdma_pkg::REG_IDX_W'(i)) begin
                rd_byte = r_regs[i];
            end
        end
        if (i_item.reg_addr == bcdma_pkg::REG_LEN) begin
            rd_byte = {7'd0, busy};
        end
    end

    assign left_dec = r_left - bcdma_pkg::t_len'(1);

    always_comb begin
        n_await     = r_await;
        n_active    = r_active;
        n_src       = r_src;
        n_dst       = r_dst;
        n_left      = r_left;
        n_src_ext   = r_src_ext;
        n_dst_ext   = r_dst_ext;
        n_vram      = r_vram;
        do_start    = 1'b0;
        o_res_valid = 1'b0;
        o_result    = '0;

        if (i_fire) begin
            case (i_item.op)
                bcdma_pkg::OP_WRITE: begin
                    if (i_item.reg_addr == bcdma_pkg::REG_LEN && !busy) begin
                        if (dst_vram) begin
                            n_await = 1'b1;
                        end else begin
                            do_start = 1'b1;
                        end
                    end
                end
                bcdma_pkg::OP_READ: begin
                    o_res_valid        = 1'b1;
                    o_result.kind      = bcdma_pkg::KIND_READ;
                    o_result.read_data = rd_byte;
                end
                bcdma_pkg::OP_VBLANK: begin
                    if (r_await) begin
                        n_await  = 1'b0;
                        do_start = 1'b1;
                    end
                end
                bcdma_pkg::OP_TICK: begin
                    if (r_active) begin
                        o_res_valid           = 1'b1;
                        o_result.kind         = bcdma_pkg::KIND_COPY;
                        o_result.src_address  = r_src_ext ? r_src
                                                          : (r_src & bcdma_pkg::CPU_RAM_MASK);
                        o_result.src_external = r_src_ext;
                        o_result.dst_address  = r_dst;
                        o_result.dst_external = r_dst_ext;
                        o_result.last_byte    = (r_left == bcdma_pkg::t_len'(1));
                        n_src                 = r_src + bcdma_pkg::t_addr'(1);
                        if (!r_vram) begin
                            n_dst = r_dst + bcdma_pkg::t_addr'(1);
                        end
                        n_left = left_dec;
                        if (left_dec == '0) begin
                            n_active = 1'b0;
                        end
                    end
                end
                default: begin
                end
            endcase
        end

        // Addresses, banks and length are latched only at the actual start.
        if (do_start) begin
            n_src_ext = src_word[15];
            n_dst_ext = dst_word[15];
            n_vram    = dst_vram;
            n_src     = bcdma_pkg::physical(src_word, n_regs[bcdma_pkg::REG_BANK_LO],
                                            n_regs[bcdma_pkg::REG_BANK_HI]);
            n_dst     = bcdma_pkg::physical(dst_word, n_regs[bcdma_pkg::REG_BANK_LO],
                                            n_regs[bcdma_pkg::REG_BANK_HI]);
            n_left    = bcdma_pkg::start_len(n_regs[bcdma_pkg::REG_LEN]);
            n_active  = (n_left != '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < bcdma_pkg::NUM_REGS; i++) begin
                r_regs[i] <= 8'd0;
            end
            r_await   <= 1'b0;
            r_active  <= 1'b0;
            r_src     <= '0;
            r_dst     <= '0;
            r_left    <= '0;
            r_src_ext <= 1'b0;
            r_dst_ext <= 1'b0;
            r_vram    <= 1'b0;
        end else begin
            r_regs    <= n_regs;
            r_await   <= n_await;
            r_active  <= n_active;
            r_src     <= n_src;
            r_dst     <= n_dst;
            r_left    <= n_left;
            r_src_ext <= n_src_ext;
            r_dst_ext <= n_dst_ext;
            r_vram    <= n_vram;
        end
    end

endmodule

FILE: hw/rtl/bcdma_out_stage.sv
// Result register of the byte copy DMA controller.
// Holds one result until the downstream side takes it; uses bcdma_pkg.
`timescale 1ns / 1ps

module bcdma_out_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  bcdma_pkg::t_result i_result,
    input  logic               i_ready,
    output logic               o_valid,
    output bcdma_pkg::t_result o_result
);

    logic               r_valid;
    logic               n_valid;
    bcdma_pkg::t_result r_result;

    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule

FILE: bench/bcdma_checker.sv
// Checker for the byte copy DMA controller: follows both stream channels, keeps its own
// copy of the register file and the copy engine, and compares every output transfer.
// Depends on bcdma_pkg.
`timescale 1ns / 1ps

module bcdma_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_axis_tvalid,
    input  logic                             i_s_axis_tready,
    // [2:0] reg_addr, [10:3] write_data, [15:11] zero
    input  logic [bcdma_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,
    // [1:0] operation
    input  logic [1:0]                       i_s_axis_tuser,
    input  logic                             i_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // [7:0] read_data, [32:8] src_address, [33] src_external,
    // [58:34] dst_address, [59] dst_external, [63:60] zero
    input  logic [bcdma_pkg::OUT_DATA_W-1:0] i_m_axis_tdata,
    // [0] kind
    input  logic                             i_m_axis_tuser,
    input  logic                             i_m_axis_tlast,
    output int                               o_fail_count,
    output int                               o_outstanding,
    output int                               o_reads_seen,
    output int                               o_copies_seen
);

    import bcdma_pkg::*;

    localparam int REPORT_LIMIT = 10;

    logic [7:0] model_regs [NUM_REGS];
    logic       vblank_wait;
    logic       copy_active;
    t_addr      src_ptr;
    t_addr      dst_ptr;
    logic [9:0] bytes_remaining;
    logic       src_is_ext;
    logic       dst_is_ext;
    logic       dst_is_port;

    t_result    results_due [$];
    t_result    got;
    int         fail_count;
    int         reads_seen;
    int         copies_seen;

    function automatic logic is_vram_port(input logic [15:0] a);
        return a == VRAM_PORT_A || a == VRAM_PORT_B;
    endfunction

    // The upper half of the address space is banked into the 25-bit physical space.
    function automatic t_addr map_address(input logic [15:0] a);
        t_addr p;
        p = '0;
        p[14:0] = a[14:0];
        if (a[15]) begin
            p[22:15] = model_regs[REG_BANK_LO];
            p[24:23] = model_regs[REG_BANK_HI][1:0];
        end
        return p;
    endfunction

    task automatic latch_copy();
        logic [15:0] s_word;
        logic [15:0] d_word;
        s_word = {model_regs[REG_SRC_HI], model_regs[REG_SRC_LO]};
        d_word = {model_regs[REG_DST_HI], model_regs[REG_DST_LO]};
        src_is_ext  = s_word[15];
        dst_is_ext  = d_word[15];
        dst_is_port = is_vram_port(d_word);
        src_ptr     = map_address(s_word);
        dst_ptr     = map_address(d_word);
        bytes_remaining = (model_regs[REG_LEN] == 8'd0) ? 10'(MAX_LENGTH)
                                                        : {1'b0, model_regs[REG_LEN], 1'b0};
        copy_active = 1'b1;
    endtask

    task automatic apply_bus_item(input t_op op, input logic [2:0] ra, input logic [7:0] wd);
        logic    busy;
        t_result r;
        busy = vblank_wait || copy_active;
        r = '0;
        case (op)
            OP_WRITE: begin
                if (ra < NUM_REGS) begin
                    model_regs[ra] = wd;
                    if (ra == REG_LEN && !busy) begin
                        if (is_vram_port({model_regs[REG_DST_HI], model_regs[REG_DST_LO]})) begin
                            vblank_wait = 1'b1;
                        end else begin
                            latch_copy();
                        end
                    end
                end
            end
            OP_READ: begin
                r.kind = KIND_READ;
                if (ra == REG_LEN) begin
                    r.read_data = {7'd0, busy};
                end else if (ra < NUM_REGS) begin
                    r.read_data = model_regs[ra];
                end
                results_due.push_back(r);
            end
            OP_VBLANK: begin
                if (vblank_wait) begin
                    vblank_wait = 1'b0;
                    latch_copy();
                end
            end
            OP_TICK: begin
                if (copy_active) begin
                    r.kind         = KIND_COPY;
                    r.src_address  = src_is_ext ? src_ptr : (src_ptr & CPU_RAM_MASK);
                    r.src_external = src_is_ext;
                    r.dst_address  = dst_ptr;
                    r.dst_external = dst_is_ext;
                    r.last_byte    = (bytes_remaining == 10'd1);
                    results_due.push_back(r);
                    src_ptr = src_ptr + 1'b1;
                    // A VRAM port destination keeps pointing at the same port.
                    if (!dst_is_port) begin
                        dst_ptr = dst_ptr + 1'b1;
                    end
                    bytes_remaining = bytes_remaining - 1'b1;
                    if (bytes_remaining == 10'd0) begin
                        copy_active = 1'b0;
                    end
                end
            end
            default: ;
        endcase
    endtask

    task automatic compare_output(input t_result act);
        t_result want;
        if (results_due.size() == 0) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT) begin
                $display("[%0t] output transfer with nothing pending: kind %0d data %h",
                         $time, act.kind, act.read_data);
            end
            return;
        end
        want = results_due.pop_front();
        if (act.kind !== want.kind || act.read_data !== want.read_data
            || act.src_address !== want.src_address || act.src_external !== want.src_external
            || act.dst_address !== want.dst_address || act.dst_external !== want.dst_external
            || act.last_byte !== want.last_byte) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT) begin
                $display("[%0t] mismatch, want: kind %0d data %h src %h/%0d dst %h/%0d last %0d",
                         $time, want.kind, want.read_data, want.src_address,
                         want.src_external, want.dst_address, want.dst_external,
                         want.last_byte);
                $display("[%0t] mismatch, got:  kind %0d data %h src %h/%0d dst %h/%0d last %0d",
                         $time, act.kind, act.read_data, act.src_address,
                         act.src_external, act.dst_address, act.dst_external, act.last_byte);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                model_regs[i] = 8'd0;
            end
            vblank_wait     = 1'b0;
            copy_active     = 1'b0;
            src_ptr         = '0;
            dst_ptr         = '0;
            bytes_remaining = '0;
            src_is_ext      = 1'b0;
            dst_is_ext      = 1'b0;
            dst_is_port     = 1'b0;
        end else begin
            // Outputs are handled first; an item accepted now cannot answer at the same edge.
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                got.kind         = i_m_axis_tuser;
                got.read_data    = i_m_axis_tdata[7:0];
                got.src_address  = i_m_axis_tdata[32:8];
                got.src_external = i_m_axis_tdata[33];
                got.dst_address  = i_m_axis_tdata[58:34];
                got.dst_external = i_m_axis_tdata[59];
                got.last_byte    = i_m_axis_tlast;
                if (got.kind == KIND_COPY) begin
                    copies_seen++;
                end else begin
                    reads_seen++;
                end
                compare_output(got);
            end
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                apply_bus_item(t_op'(i_s_axis_tuser), i_s_axis_tdata[2:0],
                               i_s_axis_tdata[10:3]);
            end
        end
        o_fail_count  <= fail_count;
        o_outstanding <= results_due.size();
        o_reads_seen  <= reads_seen;
        o_copies_seen <= copies_seen;
    end

endmodule

FILE: bench/tb.sv
// Top of the byte copy DMA controller testbench: clock, reset, bus item stimulus,
// output pacing and the final verdict. Depends on bcdma_pkg, bcdma_checker and the RTL.
`timescale 1ns / 1ps

module tb;

    import bcdma_pkg::*;

    localparam logic [REG_IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam int ITEM_TARGET = 1300;
    localparam int CYCLE_LIMIT = 300000;
    localparam int HOLD_CYCLES = 200;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_valid = 1'b0;
    logic [IN_DATA_W-1:0]  s_data = '0;
    logic [1:0]            s_user = '0;
    logic                  m_ready = 1'b0;
    logic                  s_ready;
    logic                  m_valid;
    logic [OUT_DATA_W-1:0] m_data;
    logic                  m_user;
    logic                  m_last;

    int fail_count;
    int outstanding;
    int reads_seen;
    int copies_seen;
    int cycles;

    // Stimulus bookkeeping: just enough to keep transfers well formed.
    logic [7:0]  sh_regs [NUM_REGS];
    logic        vb_wait;
    int          bytes_owed;
    int          n_items;
    int          tx_idle_pct = 23;
    int          rx_idle_pct = 69;
    bit          hold_req;
    bit          max_done;
    bit          paused;
    logic [15:0] dst_word;
    logic [7:0]  len_val;
    int          cut;
    int          pick;

    byte_copy_dma_controller i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user),
        .o_m_axis_tlast  (m_last)
    );

    bcdma_checker i_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .i_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .i_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .i_m_axis_tdata  (m_data),
        .i_m_axis_tuser  (m_user),
        .i_m_axis_tlast  (m_last),
        .o_fail_count    (fail_count),
        .o_outstanding   (outstanding),
        .o_reads_seen    (reads_seen),
        .o_copies_seen   (copies_seen)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Output side: random backpressure, plus one long hold so the block fills up.
    initial begin
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    task automatic put(input t_op op, input logic [2:0] ra, input logic [7:0] wd);
        logic busy;
        if ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < tx_idle_pct);
        end
        s_valid <= 1'b1;
        s_data  <= {5'd0, wd, ra};
        s_user  <= op;
        @(posedge i_clk);
        while (!s_ready) @(posedge i_clk);

        busy = vb_wait || bytes_owed > 0;
        case (op)
            OP_WRITE: begin
                if (ra < NUM_REGS) begin
                    sh_regs[ra] = wd;
                    if (ra == REG_LEN && !busy) begin
                        if ({sh_regs[REG_DST_HI], sh_regs[REG_DST_LO]} == VRAM_PORT_A
                            || {sh_regs[REG_DST_HI], sh_regs[REG_DST_LO]} == VRAM_PORT_B) begin
                            vb_wait = 1'b1;
                        end else begin
                            bytes_owed = int'(start_len(wd));
                        end
                    end
                end
            end
            OP_VBLANK: begin
                if (vb_wait) begin
                    vb_wait = 1'b0;
                    bytes_owed = int'(start_len(sh_regs[REG_LEN]));
                end
            end
            OP_TICK: begin
                if (bytes_owed > 0) begin
                    bytes_owed--;
                end
            end
            default: ;
        endcase

        n_items++;
        if (n_items == 430) begin
            tx_idle_pct = 69;
            rx_idle_pct = 23;
        end else if (n_items == 860) begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
        end
    endtask

    task automatic put_any();
        put(t_op'($urandom_range(3)), 3'($urandom_range(7)), 8'($urandom_range(255)));
    endtask

    initial begin
        for (int i = 0; i < NUM_REGS; i++) begin
            sh_regs[i] = 8'd0;
        end
        vb_wait = 1'b0;
        bytes_owed = 0;
        n_items = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Idle block: unused index, busy flag, stray tick and vblank.
        put(OP_READ, REG_UNUSED, 8'hFF);
        put(OP_READ, REG_LEN, 8'h00);
        put(OP_TICK, 3'd0, 8'h00);
        put(OP_VBLANK, 3'd0, 8'h00);

        // Source at the top of the banked space so its counter wraps to zero.
        put(OP_WRITE, REG_SRC_LO, 8'hFF);
        put(OP_WRITE, REG_SRC_HI, 8'hFF);
        put(OP_WRITE, REG_BANK_LO, 8'hFF);
        put(OP_WRITE, REG_BANK_HI, 8'hFF);
        put(OP_WRITE, REG_DST_LO, 8'hFF);
        put(OP_WRITE, REG_DST_HI, 8'h7F);
        put(OP_WRITE, REG_UNUSED, 8'hFF);
        put(OP_WRITE, REG_LEN, 8'h01);

        // Writes while busy are stored but leave the running transfer alone.
        put(OP_WRITE, REG_LEN, 8'hFF);
        put(OP_WRITE, REG_SRC_LO, 8'h00);
        put(OP_READ, REG_LEN, 8'h00);
        put(OP_READ, REG_SRC_LO, 8'h00);
        put(OP_TICK, 3'd7, 8'hFF);
        put(OP_TICK, 3'd0, 8'h00);
        put(OP_READ, REG_LEN, 8'h00);

        // Internal source into the VRAM port: the start waits for vblank.
        put(OP_WRITE, REG_SRC_HI, 8'h7F);
        put(OP_WRITE, REG_DST_LO, 8'h07);
        put(OP_WRITE, REG_DST_HI, 8'h20);
        put(OP_WRITE, REG_LEN, 8'h01);
        put(OP_TICK, 3'd0, 8'h00);
        put(OP_READ, REG_LEN, 8'h00);
        put(OP_VBLANK, 3'd0, 8'h00);
        put(OP_TICK, 3'd0, 8'h00);
        put(OP_TICK, 3'd0, 8'h00);

        while (n_items < ITEM_TARGET) begin
            if (!paused && n_items >= 1100) begin
                paused = 1'b1;
                s_valid <= 1'b0;
                @(posedge i_clk);
                while (outstanding != 0) @(posedge i_clk);
            end
            if ($urandom_range(99) < 80) begin
                // Finish whatever is still running, then set up and run a new transfer.
                while (vb_wait) put(OP_VBLANK, 3'($urandom), 8'($urandom));
                while (bytes_owed > 0) put(OP_TICK, 3'($urandom), 8'($urandom));
                if ($urandom_range(3) != 0) begin
                    put(OP_WRITE, REG_SRC_LO, 8'($urandom));
                    put(OP_WRITE, REG_SRC_HI, 8'($urandom));
                end
                pick = $urandom_range(99);
                if (pick < 12) begin
                    dst_word = VRAM_PORT_A;
                end else if (pick < 24) begin
                    dst_word = VRAM_PORT_B;
                end else begin
                    dst_word = 16'($urandom);
                end
                put(OP_WRITE, REG_DST_LO, dst_word[7:0]);
                put(OP_WRITE, REG_DST_HI, dst_word[15:8]);
                if ($urandom_range(3) != 0) begin
                    put(OP_WRITE, REG_BANK_LO, 8'($urandom));
                    put(OP_WRITE, REG_BANK_HI, 8'($urandom));
                end
                if ($urandom_range(1) != 0) begin
                    put(OP_READ, 3'($urandom_range(7)), 8'($urandom));
                end
                pick = $urandom_range(99);
                if (!max_done) begin
                    max_done = 1'b1;
                    len_val = 8'd0;
                end else if (pick < 88) begin
                    len_val = 8'($urandom_range(6, 1));
                end else if (pick < 98) begin
                    len_val = 8'($urandom_range(40, 7));
                end else begin
                    len_val = 8'($urandom_range(255, 41));
                end
                put(OP_WRITE, REG_LEN, len_val);
                if (vb_wait) begin
                    repeat ($urandom_range(2)) put_any();
                    if (vb_wait) begin
                        put(OP_VBLANK, 3'($urandom), 8'($urandom));
                    end
                end
                // Now and then a transfer is left unfinished for the next one to run into.
                cut = ($urandom_range(9) == 0) ? $urandom_range(bytes_owed) : 0;
                while (bytes_owed > cut) begin
                    if (!hold_req && n_items >= 950) begin
                        hold_req = 1'b1;
                    end
                    if ($urandom_range(99) < 85) begin
                        put(OP_TICK, 3'($urandom), 8'($urandom));
                    end else begin
                        put_any();
                    end
                end
            end else begin
                repeat ($urandom_range(4, 1)) put_any();
            end
        end

        s_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("Covered %0d bus items: %0d register reads and %0d byte copies checked,",
                 n_items, reads_seen, copies_seen);
        $display("under sender-heavy, receiver-heavy and unpaced handshakes.");
        if (fail_count == 0 && outstanding == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
